// ----- hdl/dqrm_pkg.sv -----
// ----------------------------------------------------------------------------
// dqrm_pkg
// Shared types and codes for the deque with remove-max.
// ----------------------------------------------------------------------------
package dqrm_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [2:0] KIND_POP_BACK   = 3'd2;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [2:0] KIND_REMOVE_MAX = 3'd4;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT_RIGHT,
    CELL_SHIFT_LEFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- hdl/dqrm_cell.sv -----
// ----------------------------------------------------------------------------
// dqrm_cell
// One storage position of the deque, with one stage of the max scan.
// ----------------------------------------------------------------------------
module dqrm_cell #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned INDEX = 0,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned OW = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dqrm_pkg::cell_ctrl_t                ctrl,
  input  logic [IW-1:0]                       pos,
  input  logic [OW-1:0]                       occ,
  input  logic signed [dqrm_pkg::DATA_W-1:0]  left_entry,
  input  logic signed [dqrm_pkg::DATA_W-1:0]  right_entry,
  input  logic                                cand_in_valid,
  input  logic signed [dqrm_pkg::DATA_W-1:0]  cand_in_value,
  input  logic [IW-1:0]                       cand_in_index,
  output logic signed [dqrm_pkg::DATA_W-1:0]  entry,
  output logic                                cand_valid,
  output logic signed [dqrm_pkg::DATA_W-1:0]  cand_value,
  output logic [IW-1:0]                       cand_index
);

  localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);
  localparam logic [OW-1:0] MY_COUNT = OW'(INDEX);

  logic own_valid;
  logic take_own;

  assign own_valid = MY_COUNT < occ;
  assign take_own  = own_valid && (!cand_in_valid || (entry > cand_in_value));

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      dqrm_pkg::CELL_WRITE: begin
        if (MY_INDEX == pos) begin
          entry <= ctrl.value;
        end
      end
      dqrm_pkg::CELL_SHIFT_RIGHT: begin
        entry <= (INDEX == 0) ? ctrl.value : left_entry;
      end
      dqrm_pkg::CELL_SHIFT_LEFT: begin
        if (MY_INDEX >= pos) begin
          entry <= right_entry;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= own_valid || cand_in_valid;
    end
    cand_value <= take_own ? entry : cand_in_value;
    cand_index <= take_own ? MY_INDEX : cand_in_index;
  end

endmodule

// ----- hdl/deque_with_remove_max_top.sv -----
// ----------------------------------------------------------------------------
// deque_with_remove_max_top
// Bounded double-ended queue of signed values with remove-max.
// ----------------------------------------------------------------------------
// Usage: drive kind and value and raise start; the command is taken at the
// rising edge where start is high and busy is low. Each command gives exactly
// one result on popped_value, status and now_empty, marked by done for one
// cycle; the receiver must take it then, since results cannot be held off.
// Pushes, pops and ignored codes need no scan: done rises the cycle
// after the transfer and busy stays low, so a command may enter every cycle.
// Remove-max on a deque of N entries runs a scan along the row of cells, one
// cell per cycle, and raises busy while it runs; done follows once the scan
// reaches the last occupied cell. On an empty deque it answers without busy.
// Reset empties the deque and returns it to idle; stored values need no
// clearing, since only occupied positions are ever read.
// ----------------------------------------------------------------------------
module deque_with_remove_max_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          kind,
  input  logic signed [dqrm_pkg::DATA_W-1:0]  value,
  output logic                                done,
  output logic signed [dqrm_pkg::DATA_W-1:0]  popped_value,
  output logic [1:0]                          status,
  output logic                                now_empty
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam logic [OW-1:0] FULL_COUNT = OW'(DEPTH);

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t                              state, state_next;
  logic [OW-1:0]                       occ, occ_next;
  logic [IW-1:0]                       cnt, cnt_next;
  logic                                done_next;
  logic signed [dqrm_pkg::DATA_W-1:0]  popped_next;
  logic [1:0]                          status_next;

  dqrm_pkg::cell_ctrl_t                ctrl;
  logic [IW-1:0]                       pos;

  logic signed [dqrm_pkg::DATA_W-1:0]  ent [DEPTH];
  logic                                cv  [DEPTH];
  logic signed [dqrm_pkg::DATA_W-1:0]  cval [DEPTH];
  logic [IW-1:0]                       cidx [DEPTH];
  logic signed [dqrm_pkg::DATA_W-1:0]  tail;
  logic signed [dqrm_pkg::DATA_W-1:0]  best_value;
  logic [IW-1:0]                       best_index;
  logic [OW-1:0]                       last;
  logic                                accept;
  logic                                is_empty;
  logic                                is_full;

  assign busy     = (state != IDLE);
  assign accept   = start && !busy;
  assign is_empty = (occ == '0);
  assign is_full  = (occ == FULL_COUNT);
  assign last     = occ - OW'(1);

  // The candidate leaving the last occupied cell covers every stored entry.
  always_comb begin
    tail       = '0;
    best_value = '0;
    best_index = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (OW'(i) == last) begin
        tail       = tail | ent[i];
        best_value = best_value | cval[i];
        best_index = best_index | cidx[i];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [dqrm_pkg::DATA_W-1:0] left_e;
    logic signed [dqrm_pkg::DATA_W-1:0] right_e;
    logic                               ci_v;
    logic signed [dqrm_pkg::DATA_W-1:0] ci_val;
    logic [IW-1:0]                      ci_idx;

    if (g == 0) begin : g_first
      assign left_e = '0;
      assign ci_v   = 1'b0;
      assign ci_val = '0;
      assign ci_idx = '0;
    end else begin : g_inner
      assign left_e = ent[g-1];
      assign ci_v   = cv[g-1];
      assign ci_val = cval[g-1];
      assign ci_idx = cidx[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_more
      assign right_e = ent[g+1];
    end

    dqrm_cell #(
      .DEPTH (DEPTH),
      .INDEX (g)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .pos           (pos),
      .occ           (occ),
      .left_entry    (left_e),
      .right_entry   (right_e),
      .cand_in_valid (ci_v),
      .cand_in_value (ci_val),
      .cand_in_index (ci_idx),
      .entry         (ent[g]),
      .cand_valid    (cv[g]),
      .cand_value    (cval[g]),
      .cand_index    (cidx[g])
    );
  end

  always_comb begin
    state_next  = state;
    occ_next    = occ;
    cnt_next    = cnt;
    done_next   = 1'b0;
    popped_next = '0;
    status_next = dqrm_pkg::STAT_DONE;
    ctrl.op     = dqrm_pkg::CELL_HOLD;
    ctrl.value  = value;
    pos         = '0;

    unique case (state)
      IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          unique case (kind)
            dqrm_pkg::KIND_PUSH_BACK: begin
              if (is_full) begin
                status_next = dqrm_pkg::STAT_FULL;
              end else begin
                ctrl.op  = dqrm_pkg::CELL_WRITE;
                pos      = occ[IW-1:0];
                occ_next = occ + OW'(1);
              end
            end
            dqrm_pkg::KIND_PUSH_FRONT: begin
              if (is_full) begin
                status_next = dqrm_pkg::STAT_FULL;
              end else begin
                ctrl.op  = dqrm_pkg::CELL_SHIFT_RIGHT;
                occ_next = occ + OW'(1);
              end
            end
            dqrm_pkg::KIND_POP_BACK: begin
              if (is_empty) begin
                status_next = dqrm_pkg::STAT_EMPTY;
              end else begin
                popped_next = tail;
                occ_next    = last;
              end
            end
            dqrm_pkg::KIND_POP_FRONT: begin
              if (is_empty) begin
                status_next = dqrm_pkg::STAT_EMPTY;
              end else begin
                ctrl.op     = dqrm_pkg::CELL_SHIFT_LEFT;
                popped_next = ent[0];
                occ_next    = last;
              end
            end
            dqrm_pkg::KIND_REMOVE_MAX: begin
              if (is_empty) begin
                status_next = dqrm_pkg::STAT_EMPTY;
              end else begin
                done_next  = 1'b0;
                cnt_next   = '0;
                state_next = SCAN;
              end
            end
            default: begin
              status_next = dqrm_pkg::STAT_DONE;
            end
          endcase
        end
      end
      SCAN: begin
        if (OW'(cnt) == last) begin
          ctrl.op     = dqrm_pkg::CELL_SHIFT_LEFT;
          pos         = best_index;
          popped_next = best_value;
          occ_next    = last;
          done_next   = 1'b1;
          state_next  = IDLE;
        end else begin
          cnt_next = cnt + IW'(1);
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      occ   <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
    popped_value <= popped_next;
    status       <= status_next;
    now_empty    <= (occ_next == '0);
  end

  a_occ_bounded: assert property (@(posedge clk) disable iff (rst)
    occ <= FULL_COUNT)
    else $error("Occupancy exceeds the depth.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == SCAN |-> (OW'(cnt) < occ) && !done)
    else $error("Scan counter ran past the occupied cells.");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && status == dqrm_pkg::STAT_FULL |-> is_full && popped_value == '0)
    else $error("Refused push reported while not full.");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> now_empty == is_empty)
    else $error("Empty flag disagrees with occupancy.");

endmodule
